[rtl/core/recent_code_duplicate_filter_core_assert.svh]
// assertion macros used by the duplicate filter checker
`ifndef RECENT_CODE_DUPLICATE_FILTER_CORE_ASSERT_SVH
`define RECENT_CODE_DUPLICATE_FILTER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RCDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcdf assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RCDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcdf assertion failed");

`endif

[rtl/core/rcdf_pkg.sv]
// shared constants and types of the recent code duplicate filter
`timescale 1ns / 1ps

package rcdf_pkg;

    // default number of remembered codes
    localparam int LIST_DEPTH_DEF = 32;

    // width of a deduplication code
    localparam int CODE_W = 16;

    // result handed from the scanner to the output stage
    typedef struct packed {
        logic valid;
        logic hit;
    } t_scan_res;

endpackage

[rtl/core/rcdf_ring_mem.sv]
// code ring storage: one write port, one registered read port
`timescale 1ns / 1ps

module rcdf_ring_mem #(
    parameter int LIST_DEPTH = rcdf_pkg::LIST_DEPTH_DEF,
    parameter int IW = $clog2(LIST_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [IW-1:0]               i_wr_addr,
    input  logic [rcdf_pkg::CODE_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [IW-1:0]               i_rd_addr,
    output logic [rcdf_pkg::CODE_W-1:0] o_rd_data
);

    logic [rcdf_pkg::CODE_W-1:0] r_mem [LIST_DEPTH];
    logic [rcdf_pkg::CODE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/rcdf_scanner.sv]
// scan sequencer: searches the live ring entries and appends a new code on a miss
`timescale 1ns / 1ps

module rcdf_scanner #(
    parameter int LIST_DEPTH = rcdf_pkg::LIST_DEPTH_DEF,
    parameter int IW = $clog2(LIST_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rcdf_pkg::CODE_W-1:0] i_code,
    output rcdf_pkg::t_scan_res         o_res,
    input  logic                        i_res_ready,
    output logic                        o_rd_en,
    output logic [IW-1:0]               o_rd_addr,
    input  logic [rcdf_pkg::CODE_W-1:0] i_rd_data,
    output logic                        o_wr_en,
    output logic [IW-1:0]               o_wr_addr,
    output logic [rcdf_pkg::CODE_W-1:0] o_wr_data
);

    // counter wide enough to hold the depth itself
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [IW-1:0] LAST_POS = IW'(LIST_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                      r_state,     n_state;
    logic [IW-1:0]               r_wpos,      n_wpos;
    logic                        r_wrapped,   n_wrapped;
    logic                        r_cmp_pend,  n_cmp_pend;
    logic                        r_cmp_last,  n_cmp_last;
    logic [CW-1:0]               r_issue_idx, n_issue_idx;
    logic [CW-1:0]               r_limit,     n_limit;
    logic [rcdf_pkg::CODE_W-1:0] r_code,      n_code;
    logic                        r_hit,       n_hit;

    logic do_load;
    logic do_miss;
    logic issue;

    assign issue = (r_issue_idx < r_limit);

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_wpos      = r_wpos;
        n_wrapped   = r_wrapped;
        n_cmp_pend  = r_cmp_pend;
        n_cmp_last  = r_cmp_last;
        n_issue_idx = r_issue_idx;
        n_limit     = r_limit;
        n_code      = r_code;
        n_hit       = r_hit;
        do_load     = 1'b0;
        do_miss     = 1'b0;
        o_rd_en     = 1'b0;
        o_ready     = 1'b0;
        o_res       = '0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                do_load = i_valid;
            end
            S_SCAN: begin
                // issue one read per cycle up to the search limit
                if (issue) begin
                    o_rd_en     = 1'b1;
                    n_issue_idx = r_issue_idx + 1'b1;
                    n_cmp_pend  = 1'b1;
                    n_cmp_last  = (r_issue_idx == r_limit - 1'b1);
                end else begin
                    n_cmp_pend = 1'b0;
                end
                // compare the entry read last cycle
                if (r_limit == '0) begin
                    do_miss = 1'b1;
                end else if (r_cmp_pend) begin
                    if (i_rd_data == r_code) begin
                        n_hit   = 1'b1;
                        n_state = S_DONE;
                    end else if (r_cmp_last) begin
                        do_miss = 1'b1;
                    end
                end
            end
            S_DONE: begin
                o_res.valid = 1'b1;
                o_res.hit   = r_hit;
                o_ready     = i_res_ready;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                    do_load = i_valid;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // start a search on an accepted transaction
        if (do_load) begin
            n_code      = i_code;
            n_limit     = r_wrapped ? DEPTH_C : CW'(r_wpos);
            n_issue_idx = '0;
            n_cmp_pend  = 1'b0;
            n_cmp_last  = 1'b0;
            n_state     = S_SCAN;
        end

        // append the new code and advance the write position
        if (do_miss) begin
            n_hit   = 1'b0;
            n_state = S_DONE;
            if (r_wpos == LAST_POS) begin
                n_wpos    = '0;
                n_wrapped = 1'b1;
            end else begin
                n_wpos = r_wpos + 1'b1;
            end
        end
    end

    // memory access
    assign o_rd_addr = r_issue_idx[IW-1:0];
    assign o_wr_en   = do_miss;
    assign o_wr_addr = r_wpos;
    assign o_wr_data = r_code;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wpos     <= '0;
            r_wrapped  <= 1'b0;
            r_cmp_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wpos     <= n_wpos;
            r_wrapped  <= n_wrapped;
            r_cmp_pend <= n_cmp_pend;
        end
    end

    // search payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_last  <= n_cmp_last;
        r_issue_idx <= n_issue_idx;
        r_limit     <= n_limit;
        r_code      <= n_code;
        r_hit       <= n_hit;
    end

endmodule

[rtl/core/recent_code_duplicate_filter_core.sv]
// top level of the recent code duplicate filter
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------
//  input     | i_valid / o_ready  | i_packet_code [15:0]
//  output    | o_valid / i_ready  | o_dup_flag
//
// an item occupies the scanner while it reads the L live entries (L being the
// write position before the first wrap, LIST_DEPTH after it) in turn through
// the single ring read port; a hit ends the scan early. reset is synchronous
// and active low.
// a finished result waits in the output register while the next search runs;
// the scanner holds its result only while that register is still occupied.
`timescale 1ns / 1ps

module recent_code_duplicate_filter_core #(
    parameter int LIST_DEPTH = rcdf_pkg::LIST_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rcdf_pkg::CODE_W-1:0] i_packet_code,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_dup_flag
);

    localparam int IW = $clog2(LIST_DEPTH);

    rcdf_pkg::t_scan_res         scan_res;
    logic                        res_ready;
    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    logic [rcdf_pkg::CODE_W-1:0] rd_data;
    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    logic [rcdf_pkg::CODE_W-1:0] wr_data;
    logic                        r_out_valid;
    logic                        r_out_dup;

    // search sequencer
    rcdf_scanner #(
        .LIST_DEPTH (LIST_DEPTH),
        .IW         (IW)
    ) u_scanner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_code      (i_packet_code),
        .o_res       (scan_res),
        .i_res_ready (res_ready),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // code ring
    rcdf_ring_mem #(
        .LIST_DEPTH (LIST_DEPTH),
        .IW         (IW)
    ) u_ring_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (scan_res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_res.valid && res_ready) begin
            r_out_dup <= scan_res.hit;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_dup_flag = r_out_dup;

endmodule

[rtl/core/rcdf_checker.sv]
// port-level checks of the duplicate filter and their binding
`timescale 1ns / 1ps
`include "recent_code_duplicate_filter_core_assert.svh"

module rcdf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_dup_flag
);

    logic in_txn;
    logic out_stall;

    assign in_txn    = i_valid && o_ready;
    assign out_stall = o_valid && !i_ready;

    // a stalled result keeps its value
    `RCDF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_valid && $stable(o_dup_flag))

    // one search at a time: the input closes right after a transaction
    `RCDF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_txn, !o_ready)

    // a search never completes at once: the input closes after every transaction
    `RCDF_ASSERT_NOW(a_min_search, i_clk, i_rst_n, $past(in_txn) && $past(i_rst_n), !o_ready)

endmodule

bind recent_code_duplicate_filter_core rcdf_checker u_rcdf_checker (.*);

[test/recent_code_duplicate_filter_core_tb.sv]
// testbench for the recent code duplicate filter: random traffic checked by a scoreboard
`timescale 1ns / 1ps

// outcome of comparing one output transaction with the oldest expectation
typedef enum int {
    CHK_OK,
    CHK_UNEXPECTED,
    CHK_MISMATCH
} t_chk_status;

// predicts the duplicate flag of each accepted code and queues it
class dup_scoreboard;
    localparam int DEPTH = rcdf_pkg::LIST_DEPTH_DEF;
    localparam int POS_W = $clog2(DEPTH);

    bit [rcdf_pkg::CODE_W-1:0] code_ring [DEPTH];
    bit [POS_W-1:0]            wr_pos;
    bit                        wrapped;
    bit                        dup_flags_q [$];

    function new();
        wr_pos  = '0;
        wrapped = 1'b0;
    endfunction

    // search the live entries, store the code on a miss, queue the flag
    function void note_code(bit [rcdf_pkg::CODE_W-1:0] code);
        int live;
        bit hit;
        hit  = 1'b0;
        live = wrapped ? DEPTH : int'(wr_pos);
        for (int k = 0; k < live; k++) begin
            if (code_ring[k] == code) begin
                hit = 1'b1;
            end
        end
        if (!hit) begin
            code_ring[wr_pos] = code;
            if (int'(wr_pos) == DEPTH - 1) begin
                wr_pos  = '0;
                wrapped = 1'b1;
            end else begin
                wr_pos = wr_pos + 1'b1;
            end
        end
        dup_flags_q.push_back(hit);
    endfunction

    // compare an output flag with the oldest expected flag
    function t_chk_status check_result(bit got, output bit want);
        want = 1'b0;
        if (dup_flags_q.size() == 0) begin
            return CHK_UNEXPECTED;
        end
        want = dup_flags_q.pop_front();
        return (want == got) ? CHK_OK : CHK_MISMATCH;
    endfunction

    function int pending();
        return dup_flags_q.size();
    endfunction
endclass

module recent_code_duplicate_filter_core_tb;

    localparam int DEPTH       = rcdf_pkg::LIST_DEPTH_DEF;
    localparam int CODE_W      = rcdf_pkg::CODE_W;
    localparam int N_RANDOM    = 1180;
    localparam int HIST_LEN    = 48;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTS  = 40;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_valid        = 1'b0;
    logic                        o_ready;
    logic [rcdf_pkg::CODE_W-1:0] i_packet_code  = '0;
    logic                        o_valid;
    logic                        i_ready        = 1'b0;
    logic                        o_dup_flag;

    dup_scoreboard sb = new();

    int unsigned error_count  = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;
    int unsigned burst_left   = 0;

    recent_code_duplicate_filter_core #(
        .LIST_DEPTH(DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_packet_code (i_packet_code),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_dup_flag    (o_dup_flag)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // print one mismatch line (up to MAX_PRINTS of them) and count it
    task automatic report_mismatch(string what);
        if (error_count < MAX_PRINTS) begin
            $display("%0t ns: error: %s", $time, what);
        end
        error_count++;
    endtask

    // gap before the next input transaction: bursts, short gaps, rare long ones
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if (r < 8) begin
            burst_left = $urandom_range(10, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 92) return int'($urandom_range(1, 4));
        return int'($urandom_range(20, 80));
    endfunction

    // offer one code after a gap and hold it until accepted
    task automatic send_code(logic [rcdf_pkg::CODE_W-1:0] code, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_packet_code <= code;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
    endtask

    // monitor both channels: note accepted codes, check output transactions
    always @(posedge i_clk) begin : monitor
        t_chk_status st;
        bit          want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_code(i_packet_code);
            end
            if (o_valid && i_ready) begin
                results_seen++;
                st = sb.check_result(o_dup_flag, want);
                if (st == CHK_UNEXPECTED) begin
                    report_mismatch("output transaction with no expectation waiting");
                end else if (st == CHK_MISMATCH) begin
                    report_mismatch($sformatf("dup flag %0b, expected %0b",
                                              o_dup_flag, want));
                end
            end
        end
    end

    // receiver: random ready stretches and one long hold-off
    initial begin : receiver
        int  r;
        int  len;
        bit  level;
        bit  hold_done;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            r = int'($urandom_range(0, 99));
            if (!hold_done && results_seen >= 300) begin
                hold_done = 1'b1;
                level     = 1'b0;
                len       = HOLD_CYCLES;
            end else if (r < 10) begin
                level = 1'b1;
                len   = int'($urandom_range(50, 150));
            end else if (r < 60) begin
                level = 1'b1;
                len   = int'($urandom_range(1, 20));
            end else if (r < 92) begin
                level = 1'b0;
                len   = int'($urandom_range(1, 3));
            end else begin
                level = 1'b0;
                len   = int'($urandom_range(10, 60));
            end
            i_ready <= level;
            repeat (len) @(posedge i_clk);
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        logic [rcdf_pkg::CODE_W-1:0] directed_codes [18];
        logic [rcdf_pkg::CODE_W-1:0] code;
        logic [rcdf_pkg::CODE_W-1:0] history_q [$];
        int                          r;

        // extremes, repeats and a few alternating patterns
        directed_codes = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                           16'h7FFF, 16'h0001, 16'h8000, 16'hAAAA, 16'h5555, 16'hAAAA,
                           16'h5555, 16'h0000, 16'h1234, 16'hFFFE, 16'hFFFE, 16'h0002};

        // reset
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (directed_codes[k]) begin
            send_code(directed_codes[k], pick_gap());
        end

        // random part: repeats of recent codes, a small pool, and fresh codes
        for (int n = 0; n < N_RANDOM; n++) begin
            r = int'($urandom_range(0, 99));
            if (r < 30 && history_q.size() > 0) begin
                code = history_q[$urandom_range(0, history_q.size() - 1)];
            end else if (r < 45) begin
                code = CODE_W'($urandom_range(0, 15));
            end else begin
                code = CODE_W'($urandom);
            end
            history_q.push_back(code);
            if (history_q.size() > HIST_LEN) begin
                void'(history_q.pop_front());
            end
            send_code(code, pick_gap());
        end
        i_valid <= 1'b0;

        // drain, then let the block settle
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2 * DEPTH + 8) @(posedge i_clk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
